// ===== hw/rtl/roll_pid_motor_mix_defines.svh =====
`ifndef ROLL_PID_MOTOR_MIX_DEFINES_SVH
`define ROLL_PID_MOTOR_MIX_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RPMM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpmm check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define RPMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpmm check failed");

`endif

// ===== hw/rtl/rpmm_pkg.sv =====
`timescale 1ns / 1ps
package rpmm_pkg;

  localparam int CFG_W   = 15;
  localparam int IDX_W   = 3;
  localparam int PWM_W   = 15;
  localparam int TGT_W   = 14;
  localparam int GAIN_W  = 8;
  localparam int SHIFT_W = 4;
  localparam int DRIVE_W = 32;

  // drive is held in 1/2048 pwm count, gains are scaled by 128
  localparam int FRAC_BITS  = 11;
  localparam int GAIN_SHIFT = 7;

  // base * 2048 -/+ drive, signed
  localparam int MOT_W = PWM_W + FRAC_BITS + 1 + 1 > DRIVE_W + 1
                       ? PWM_W + FRAC_BITS + 2 : DRIVE_W + 2;

  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TARGET_ROLL = 3'd0;
  localparam cfg_idx_t REG_BASE_PWM_A  = 3'd1;
  localparam cfg_idx_t REG_BASE_PWM_B  = 3'd2;
  localparam cfg_idx_t REG_P_GAIN      = 3'd3;
  localparam cfg_idx_t REG_D_GAIN      = 3'd4;
  localparam cfg_idx_t REG_I_SHIFT     = 3'd5;
  localparam cfg_idx_t REG_PWM_FLOOR   = 3'd6;
  localparam cfg_idx_t REG_PWM_CEILING = 3'd7;

  localparam logic signed [TGT_W-1:0] RST_TARGET_ROLL = 14'sd0;
  localparam logic [PWM_W-1:0]        RST_BASE_PWM    = 15'd1100;
  localparam logic [GAIN_W-1:0]       RST_P_GAIN      = 8'd8;
  localparam logic [GAIN_W-1:0]       RST_D_GAIN      = 8'd34;
  localparam logic [SHIFT_W-1:0]      RST_I_SHIFT     = 4'd7;
  localparam logic [PWM_W-1:0]        RST_PWM_FLOOR   = 15'd960;
  localparam logic [PWM_W-1:0]        RST_PWM_CEILING = 15'd1840;

endpackage

// ===== hw/rtl/roll_pid_motor_mix.sv =====
// path: an accepted sample beat passes the stage 1 and stage 2 registers to the output register
// throughput: one sample per cycle while in_ready is high; the integral and previous roll update on accept
// stall: a held output fills the two inner stages before in_ready drops
// reset: rst (sync, active high) empties the pipe, zeroes the integral and previous
// roll, and loads the register defaults
`timescale 1ns / 1ps
module roll_pid_motor_mix
  import rpmm_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int INTEGRAL_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [IDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] roll_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PWM_W-1:0]             motor_a,
  output logic [PWM_W-1:0]             motor_b,
  output logic signed [DRIVE_W-1:0]    drive_term
);

  localparam int EW   = (ANGLE_BITS > TGT_W ? ANGLE_BITS : TGT_W) + 1;
  localparam int DW   = ANGLE_BITS + 1;
  localparam int IW1  = (INTEGRAL_BITS > EW ? INTEGRAL_BITS : EW) + 1;
  localparam int PW   = EW + GAIN_W + 1;
  localparam int DPW  = DW + GAIN_W + 1;
  localparam int SUMW = PW + 1;
  localparam int AW   = SUMW + GAIN_SHIFT;
  localparam int BW   = INTEGRAL_BITS + GAIN_SHIFT;
  localparam int DRW  = (AW > BW ? AW : BW) + 1;
  localparam int QW   = MOT_W - FRAC_BITS;

  // configuration
  logic signed [TGT_W-1:0] target_roll;
  logic [PWM_W-1:0]        base_pwm_a;
  logic [PWM_W-1:0]        base_pwm_b;
  logic [GAIN_W-1:0]       p_gain;
  logic [GAIN_W-1:0]       d_gain;
  logic [SHIFT_W-1:0]      i_shift;
  logic [PWM_W-1:0]        pwm_floor;
  logic [PWM_W-1:0]        pwm_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_roll <= RST_TARGET_ROLL;
      base_pwm_a  <= RST_BASE_PWM;
      base_pwm_b  <= RST_BASE_PWM;
      p_gain      <= RST_P_GAIN;
      d_gain      <= RST_D_GAIN;
      i_shift     <= RST_I_SHIFT;
      pwm_floor   <= RST_PWM_FLOOR;
      pwm_ceiling <= RST_PWM_CEILING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_ROLL: target_roll <= $signed(cfg_data[TGT_W-1:0]);
        REG_BASE_PWM_A:  base_pwm_a  <= cfg_data[PWM_W-1:0];
        REG_BASE_PWM_B:  base_pwm_b  <= cfg_data[PWM_W-1:0];
        REG_P_GAIN:      p_gain      <= cfg_data[GAIN_W-1:0];
        REG_D_GAIN:      d_gain      <= cfg_data[GAIN_W-1:0];
        REG_I_SHIFT:     i_shift     <= cfg_data[SHIFT_W-1:0];
        REG_PWM_FLOOR:   pwm_floor   <= cfg_data[PWM_W-1:0];
        REG_PWM_CEILING: pwm_ceiling <= cfg_data[PWM_W-1:0];
      endcase
    end
  end

  // pipeline control
  logic v1, v2, v3;
  logic adv3, s2_free, accept;

  assign adv3     = !v3 || out_ready;
  assign s2_free  = !v2 || adv3;
  assign in_ready = !v1 || s2_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (s2_free) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage 1: error, difference, integral update, gain products
  logic signed [ANGLE_BITS-1:0]    previous_roll;
  logic signed [INTEGRAL_BITS-1:0] roll_integral;
  logic signed [INTEGRAL_BITS-1:0] roll_integral_next;
  logic signed [EW-1:0]            err;
  logic signed [DW-1:0]            diff;
  logic signed [IW1-1:0]           integ_sum;
  logic [IW1-INTEGRAL_BITS:0]      integ_top;
  logic signed [PW-1:0]            p_prod, p_prod_next;
  logic signed [DPW-1:0]           d_prod, d_prod_next;
  logic signed [INTEGRAL_BITS-1:0] integ;

  always_comb begin
    err       = EW'(target_roll) - EW'(roll_sample);
    diff      = DW'(previous_roll) - DW'(roll_sample);
    integ_sum = IW1'(roll_integral) + IW1'(err);
    integ_top = integ_sum[IW1-1:INTEGRAL_BITS-1];
    if (&integ_top || !(|integ_top)) begin
      roll_integral_next = integ_sum[INTEGRAL_BITS-1:0];
    end else begin
      roll_integral_next = {integ_sum[IW1-1], {(INTEGRAL_BITS-1){~integ_sum[IW1-1]}}};
    end
    p_prod_next = PW'($signed({1'b0, p_gain})) * PW'(err);
    d_prod_next = DPW'($signed({1'b0, d_gain})) * DPW'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_roll <= '0;
      roll_integral <= '0;
    end else if (accept) begin
      previous_roll <= roll_sample;
      roll_integral <= roll_integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_prod <= p_prod_next;
      d_prod <= d_prod_next;
      integ  <= roll_integral_next;
    end
  end

  // stage 2: scale, shift the integral, saturate the drive
  logic signed [SUMW-1:0]    pd_sum;
  logic signed [DRW-1:0]     pd_scaled, i_scaled, drive_wide;
  logic [DRW-DRIVE_W:0]      drive_top;
  logic signed [DRIVE_W-1:0] drive_sat, drive2;

  always_comb begin
    pd_sum     = SUMW'(p_prod) + SUMW'(d_prod);
    pd_scaled  = DRW'(pd_sum) <<< GAIN_SHIFT;
    i_scaled   = (DRW'(integ) <<< GAIN_SHIFT) >>> i_shift;
    drive_wide = pd_scaled + i_scaled;
    drive_top  = drive_wide[DRW-1:DRIVE_W-1];
    if (&drive_top || !(|drive_top)) begin
      drive_sat = drive_wide[DRIVE_W-1:0];
    end else begin
      drive_sat = {drive_wide[DRW-1], {(DRIVE_W-1){~drive_wide[DRW-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && v1) drive2 <= drive_sat;
  end

  // stage 3: motor mix, truncate toward zero, ceiling then floor
  function automatic logic [PWM_W-1:0] mix_motor(
    input logic signed [MOT_W-1:0] x,
    input logic [PWM_W-1:0]        lo,
    input logic [PWM_W-1:0]        hi
  );
    logic signed [QW-1:0] q;
    logic                 rnd;
    rnd = x[MOT_W-1] && (|x[FRAC_BITS-1:0]);
    q   = $signed(x[MOT_W-1:FRAC_BITS]) + $signed(QW'({1'b0, rnd}));
    // floor is compared against the already clamped value
    if (q > $signed({1'b0, hi})) q = $signed(QW'({1'b0, hi}));
    if (q < $signed({1'b0, lo})) q = $signed(QW'({1'b0, lo}));
    return q[PWM_W-1:0];
  endfunction

  logic signed [MOT_W-1:0] x_a, x_b;

  always_comb begin
    x_a = $signed(MOT_W'({base_pwm_a, {FRAC_BITS{1'b0}}})) - MOT_W'(drive2);
    x_b = $signed(MOT_W'({base_pwm_b, {FRAC_BITS{1'b0}}})) + MOT_W'(drive2);
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      motor_a    <= mix_motor(x_a, pwm_floor, pwm_ceiling);
      motor_b    <= mix_motor(x_b, pwm_floor, pwm_ceiling);
      drive_term <= drive2;
    end
  end

  assign out_valid = v3;

endmodule

// ===== hw/rtl/rpmm_checker.sv =====
`timescale 1ns / 1ps
`include "roll_pid_motor_mix_defines.svh"
module rpmm_checker
  import rpmm_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [PWM_W-1:0]             motor_a,
  input logic [PWM_W-1:0]             motor_b,
  input logic signed [DRIVE_W-1:0]    drive_term
);

  // pipe comes out of reset empty and open
  `RPMM_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid && in_ready)

  // a fresh result beat must trace back to an earlier accepted sample beat
  `RPMM_ASSERT_IMP(a_rose_needs_accept, $rose(out_valid), $past(in_valid && in_ready, 3))

  // stalled result beat holds
  `RPMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(motor_a) && $stable(motor_b) && $stable(drive_term))

endmodule

bind roll_pid_motor_mix rpmm_checker u_rpmm_checker (.*);

// ===== sim/roll_pid_motor_mix_checker.sv =====
`timescale 1ns / 1ps
module roll_pid_motor_mix_checker
  import rpmm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [15:0]        roll_sample,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [PWM_W-1:0]          motor_a,
  input  logic [PWM_W-1:0]          motor_b,
  input  logic signed [DRIVE_W-1:0] drive_term,
  output int                        mismatches,
  output int                        pending
);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic [PWM_W-1:0]          motor_a;
    logic [PWM_W-1:0]          motor_b;
    logic signed [DRIVE_W-1:0] drive;
  } motor_cmd_t;

  motor_cmd_t cmd_q[$];

  logic signed [TGT_W-1:0] target_roll;
  logic [PWM_W-1:0]        base_a;
  logic [PWM_W-1:0]        base_b;
  logic [GAIN_W-1:0]       p_gain;
  logic [GAIN_W-1:0]       d_gain;
  logic [SHIFT_W-1:0]      i_shift;
  logic [PWM_W-1:0]        floor_cmd;
  logic [PWM_W-1:0]        ceiling_cmd;
  logic signed [15:0]      last_roll;
  longint                  roll_integral;
  int                      fail_count = 0;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic longint clip32(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // truncating divide, then ceiling first so the floor wins when they cross
  function automatic logic [PWM_W-1:0] mix_motor(logic [PWM_W-1:0] base, longint offset);
    longint q;
    q = (longint'(base) * 2048 + offset) / 2048;
    if (q > longint'(ceiling_cmd)) q = ceiling_cmd;
    if (q < longint'(floor_cmd)) q = floor_cmd;
    return q[PWM_W-1:0];
  endfunction

  function automatic motor_cmd_t predict_mix(logic signed [15:0] roll);
    longint err;
    longint slope;
    longint drive;
    motor_cmd_t cmd;
    err = longint'(target_roll) - longint'(roll);
    slope = longint'(last_roll) - longint'(roll);
    roll_integral = clip32(roll_integral + err);
    drive = (longint'(p_gain) * err + longint'(d_gain) * slope) * 128
          + ((roll_integral * 128) >>> i_shift);
    drive = clip32(drive);
    cmd.motor_a = mix_motor(base_a, -drive);
    cmd.motor_b = mix_motor(base_b, drive);
    cmd.drive = drive[DRIVE_W-1:0];
    last_roll = roll;
    return cmd;
  endfunction

  always @(posedge clk) begin
    motor_cmd_t want;
    if (rst) begin
      target_roll = RST_TARGET_ROLL;
      base_a = RST_BASE_PWM;
      base_b = RST_BASE_PWM;
      p_gain = RST_P_GAIN;
      d_gain = RST_D_GAIN;
      i_shift = RST_I_SHIFT;
      floor_cmd = RST_PWM_FLOOR;
      ceiling_cmd = RST_PWM_CEILING;
      last_roll = '0;
      roll_integral = 0;
      cmd_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_ROLL: target_roll = cfg_data[TGT_W-1:0];
          REG_BASE_PWM_A:  base_a = cfg_data[PWM_W-1:0];
          REG_BASE_PWM_B:  base_b = cfg_data[PWM_W-1:0];
          REG_P_GAIN:      p_gain = cfg_data[GAIN_W-1:0];
          REG_D_GAIN:      d_gain = cfg_data[GAIN_W-1:0];
          REG_I_SHIFT:     i_shift = cfg_data[SHIFT_W-1:0];
          REG_PWM_FLOOR:   floor_cmd = cfg_data[PWM_W-1:0];
          REG_PWM_CEILING: ceiling_cmd = cfg_data[PWM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          $error("motor beat with no command expected: a=%0d b=%0d drive=%0d",
                 motor_a, motor_b, drive_term);
          fail_count++;
        end else begin
          want = cmd_q.pop_front();
          if (motor_a !== want.motor_a) begin
            $error("motor_a: expected %0d, got %0d", want.motor_a, motor_a);
            fail_count++;
          end
          if (motor_b !== want.motor_b) begin
            $error("motor_b: expected %0d, got %0d", want.motor_b, motor_b);
            fail_count++;
          end
          if (drive_term !== want.drive) begin
            $error("drive_term: expected %0d, got %0d", want.drive, drive_term);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        cmd_q.push_back(predict_mix(roll_sample));
      end
    end
    mismatches <= fail_count;
    pending <= cmd_q.size();
  end

endmodule

// ===== sim/roll_pid_motor_mix_tb.sv =====
`timescale 1ns / 1ps
module roll_pid_motor_mix_tb;
  import rpmm_pkg::*;

  localparam int ROLL_W      = 16;
  localparam int STALL_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [IDX_W-1:0]          cfg_index = REG_TARGET_ROLL;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ROLL_W-1:0]  roll_sample = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [PWM_W-1:0]          motor_a;
  logic [PWM_W-1:0]          motor_b;
  logic signed [DRIVE_W-1:0] drive_term;

  int mismatches;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_count = 0;

  roll_pid_motor_mix DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .roll_sample(roll_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .motor_a    (motor_a),
    .motor_b    (motor_b),
    .drive_term (drive_term)
  );

  roll_pid_motor_mix_checker mix_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .roll_sample(roll_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .motor_a    (motor_a),
    .motor_b    (motor_b),
    .drive_term (drive_term),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog on cycles where no beat moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // receiver back-pressure in bursts
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_roll(input logic signed [ROLL_W-1:0] roll);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    roll_sample <= roll;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every motor command is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] target, base_a, base_b, kp, kd,
                               shift, lo, hi);
    logic [CFG_W-1:0] reg_word [8];
    reg_word[REG_TARGET_ROLL] = target;
    reg_word[REG_BASE_PWM_A]  = base_a;
    reg_word[REG_BASE_PWM_B]  = base_b;
    reg_word[REG_P_GAIN]      = kp;
    reg_word[REG_D_GAIN]      = kd;
    reg_word[REG_I_SHIFT]     = shift;
    reg_word[REG_PWM_FLOOR]   = lo;
    reg_word[REG_PWM_CEILING] = hi;
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= reg_word[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_value(int lo, int hi, int width);
    case ($urandom_range(0, 3))
      0: return CFG_W'(lo);
      1: return CFG_W'(hi);
      2: return CFG_W'(lo + int'($urandom_range(0, hi - lo)));
      default: return CFG_W'($urandom_range(0, (1 << width) - 1));
    endcase
  endfunction

  function automatic int burst_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  task automatic random_settings();
    if ($urandom_range(0, 1)) begin
      // flight-like tuning around hover throttle
      load_settings(CFG_W'(int'($urandom_range(0, 1000)) - 500),
                    CFG_W'($urandom_range(1000, 1700)), CFG_W'($urandom_range(1000, 1700)),
                    CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 80)),
                    CFG_W'($urandom_range(4, 12)),
                    CFG_W'($urandom_range(800, 1100)), CFG_W'($urandom_range(1600, 2000)));
    end else begin
      load_settings(pick_value(-5760, 5760, TGT_W),
                    pick_value(0, 18400, PWM_W), pick_value(0, 18400, PWM_W),
                    pick_value(0, 255, GAIN_W), pick_value(0, 255, GAIN_W),
                    pick_value(0, 15, SHIFT_W),
                    pick_value(0, 18400, PWM_W), pick_value(0, 18400, PWM_W));
    end
  endtask

  // mostly a smooth attitude walk, with jumps and rail values mixed in
  task automatic run_flight(input int count);
    logic signed [ROLL_W-1:0] roll;
    int angle;
    int pick;
    angle = int'($urandom_range(0, 2000)) - 1000;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        angle += int'($urandom_range(0, 400)) - 200;
        if (angle > 5760) angle = 5760;
        if (angle < -5760) angle = -5760;
        roll = ROLL_W'(angle);
      end else if (pick < 95) begin
        roll = ROLL_W'($urandom_range(0, 65535));
      end else begin
        roll = pick[0] ? 16'sh7FFF : 16'sh8000;
      end
      if ($urandom_range(0, 99) < 2) drain();
      send_roll(roll);
    end
  endtask

  task automatic run_windup(input int count, input int base_roll, input int span);
    for (int n = 0; n < count; n++) begin
      send_roll(ROLL_W'(base_roll + int'($urandom_range(0, span))));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset tuning; first beat sees a zero previous roll
    idle_pct = 20;
    stall_pct = 20;
    send_roll(16);
    send_roll(0);
    send_roll(16'sh7FFF);
    send_roll(16'sh8000);
    send_roll(16'sh7FFF);
    send_roll(-1);
    send_roll(1);
    send_roll(5760);
    send_roll(-5760);
    send_roll(0);
    drain();

    // full gains and no integral shift push the drive into saturation
    load_settings(8191, 0, 32767, 255, 255, 0, 0, 32767);
    send_roll(16'sh8000);
    send_roll(16'sh7FFF);
    send_roll(16'sh8000);
    send_roll(0);
    send_roll(1);
    drain();

    // floor above ceiling
    load_settings(CFG_W'(-8192), 32767, 0, 0, 0, 15, 32767, 0);
    send_roll(100);
    send_roll(-100);
    send_roll(0);
    send_roll(12345);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_settings();
      idle_pct = burst_pct();
      stall_pct = burst_pct();
      run_flight(90);
      drain();
    end

    // integral windup toward the positive rail and then toward the negative rail
    idle_pct = 2;
    stall_pct = 2;
    load_settings(8191, 1100, 1100, 1, 1, 15, 0, 32767);
    run_windup(30, -32768, 768);
    drain();
    load_settings(CFG_W'(-8192), 1100, 1100, 1, 1, 15, 0, 32767);
    run_windup(30, 32000, 767);
    drain();

    // closing stretch at full rate on both sides
    random_settings();
    idle_pct = 0;
    stall_pct = 0;
    run_flight(100);
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
